// ----- hdl/skl_pkg.sv -----
// ----------------------------------------------------------------------------
// skl_pkg: shared types and constants of the sorted key list
// Field widths, command and status codes, and the control word that the
// top level broadcasts to every cell of the list.
// ----------------------------------------------------------------------------
package skl_pkg;

  // Fixed field widths.
  localparam int unsigned KeyBits     = 31;
  localparam int unsigned StatusBits  = 2;
  localparam int unsigned TotalBits   = 32;
  localparam int unsigned OccBits     = 7;

  // Default sizes for the top-level parameters.
  localparam int unsigned DefCapacity   = 64;
  localparam int unsigned DefHandleBits = 16;

  // Request commands, carried on the slave tuser bit.
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  // Result status codes, carried on the master tuser bits.
  localparam logic [StatusBits-1:0] STATUS_DONE      = 2'd0;
  localparam logic [StatusBits-1:0] STATUS_EMPTY     = 2'd1;
  localparam logic [StatusBits-1:0] STATUS_FULL      = 2'd2;
  localparam logic [StatusBits-1:0] STATUS_NOT_FOUND = 2'd3;

  // What every cell does in the update cycle.
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2
  } cell_op_e;

  // Broadcast control word for the cell row.
  typedef struct packed {
    cell_op_e          op;
    logic [KeyBits-1:0] key;
  } cell_ctrl_t;

endpackage

// ----- hdl/skl_cell.sv -----
// ----------------------------------------------------------------------------
// skl_cell: one entry of the sorted key list
// Holds one key and handle, compares its key with the broadcast key and
// shifts toward either neighbor when an entry is inserted or removed.
// ----------------------------------------------------------------------------
module skl_cell #(
  parameter int unsigned INDEX       = 0,
  parameter int unsigned CNT_W       = 7,
  parameter int unsigned HANDLE_BITS = 16
) (
  input  logic                        clk_i,
  input  skl_pkg::cell_ctrl_t         ctrl_i,
  input  logic [HANDLE_BITS-1:0]      handle_i,
  input  logic [CNT_W-1:0]            count_i,
  input  logic                        left_lt_i,
  input  logic [skl_pkg::KeyBits-1:0] left_key_i,
  input  logic [HANDLE_BITS-1:0]      left_handle_i,
  input  logic [skl_pkg::KeyBits-1:0] right_key_i,
  input  logic [HANDLE_BITS-1:0]      right_handle_i,
  output logic [skl_pkg::KeyBits-1:0] key_o,
  output logic [HANDLE_BITS-1:0]      handle_o,
  output logic                        lt_o,
  output logic                        bound_o,
  output logic                        hit_o
);

  logic [skl_pkg::KeyBits-1:0] key_q, key_d;
  logic [HANDLE_BITS-1:0]      handle_q, handle_d;
  logic                        occupied;

  // The entry is live when its place lies below the entry count.
  assign occupied = CNT_W'(INDEX) < count_i;

  // Since the list is sorted, the live cells with a smaller key form a prefix;
  // the first cell outside it marks the search position.
  assign lt_o    = occupied && (key_q < ctrl_i.key);
  assign bound_o = left_lt_i && !lt_o;
  assign hit_o   = bound_o && occupied && (key_q == ctrl_i.key);

  // Next entry value: keep, take the new entry, or shift from a neighbor.
  always_comb begin
    key_d    = key_q;
    handle_d = handle_q;
    case (ctrl_i.op)
      skl_pkg::OP_INSERT: begin
        if (bound_o) begin
          key_d    = ctrl_i.key;
          handle_d = handle_i;
        end else if (!lt_o) begin
          key_d    = left_key_i;
          handle_d = left_handle_i;
        end
      end
      skl_pkg::OP_DELETE: begin
        if (!lt_o) begin
          key_d    = right_key_i;
          handle_d = right_handle_i;
        end
      end
      default: begin
        key_d    = key_q;
        handle_d = handle_q;
      end
    endcase
  end

  // Entry storage; contents are meaningless until written.
  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    handle_q <= handle_d;
  end

  assign key_o    = key_q;
  assign handle_o = handle_q;

endmodule

// ----- hdl/skl_pos_enc.sv -----
// ----------------------------------------------------------------------------
// skl_pos_enc: search position encoder
// Turns the one-hot boundary flags of the cell row into the number of
// entries with a smaller key.
// ----------------------------------------------------------------------------
module skl_pos_enc #(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned CNT_W    = 7
) (
  input  logic [CAPACITY-1:0] bound_i,
  output logic [CNT_W-1:0]    pos_o
);

  // OR together the indexes of the flagged cells. With no flag every live
  // cell holds a smaller key, which happens only in a full list.
  always_comb begin
    pos_o = '0;
    for (int unsigned i = 0; i < CAPACITY; i++) begin
      if (bound_i[i]) begin
        pos_o = pos_o | CNT_W'(i);
      end
    end
    if (bound_i == '0) begin
      pos_o = CNT_W'(CAPACITY);
    end
  end

endmodule

// ----- hdl/sorted_key_list.sv -----
// ----------------------------------------------------------------------------
// sorted_key_list: bounded table of key and handle entries in key order
// A request is first registered; in the update step every cell then compares
// its key with the request key and the row shifts to insert or remove an
// entry, and in the charge step the search compares are added to the
// saturating total, waiting until the output register is free or being read;
// only then is the next request accepted. The result sits in an output
// register, so a new request is taken while an earlier result waits on the
// master side. An insert goes ahead of equal keys; a delete removes the
// first equal key, and an absent key reports not found while still charging
// the search compares. Entry storage has no reset and needs no clearing pass.
// ----------------------------------------------------------------------------
module sorted_key_list #(
  parameter int unsigned CAPACITY    = skl_pkg::DefCapacity,
  parameter int unsigned HANDLE_BITS = skl_pkg::DefHandleBits,
  localparam int unsigned CNT_W      = $clog2(CAPACITY + 1),
  localparam int unsigned IN_W       = ((skl_pkg::KeyBits + HANDLE_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W      = ((skl_pkg::TotalBits + skl_pkg::OccBits + 7) / 8) * 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // key, record_handle (from bit 0 up), zero padded to whole bytes
  input  logic [IN_W-1:0]                  s_axis_tdata,
  // cmd
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // compare_total, occupancy (from bit 0 up), zero padded to whole bytes
  output logic [OUT_W-1:0]                 m_axis_tdata,
  // status
  output logic [skl_pkg::StatusBits-1:0]   m_axis_tuser
);

  localparam int unsigned KB = skl_pkg::KeyBits;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_EXEC   = 2'd1;
  localparam logic [1:0] ST_CHARGE = 2'd2;

  logic [1:0]                     state_q, state_d;
  logic                           cmd_q;
  logic [KB-1:0]                  key_q;
  logic [HANDLE_BITS-1:0]         handle_q;
  logic [CNT_W-1:0]               count_q, count_d;
  logic [CNT_W-1:0]               old_count_q;
  logic [CNT_W-1:0]               pos_q;
  logic                           charge_q;
  logic [skl_pkg::StatusBits-1:0] status_q, status_d;
  logic [skl_pkg::TotalBits-1:0]  total_q;
  logic [skl_pkg::TotalBits:0]    sum;
  logic [CNT_W-1:0]               pos_inc, charge_amt;
  logic                           out_valid_q;
  logic [skl_pkg::StatusBits-1:0] out_status_q;
  logic [skl_pkg::TotalBits-1:0]  out_total_q;
  logic [skl_pkg::OccBits-1:0]    out_occ_q;
  logic                           in_req, out_take, out_free;
  logic                           full, empty, found;
  logic [CNT_W-1:0]               pos;
  skl_pkg::cell_ctrl_t            ctrl;

  logic [KB-1:0]          key_w    [CAPACITY];
  logic [HANDLE_BITS-1:0] handle_w [CAPACITY];
  logic [CAPACITY-1:0]    lt_w, bound_w, hit_w;

  assign in_req   = s_axis_tvalid && s_axis_tready;
  assign out_take = m_axis_tvalid && m_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign full     = count_q == CNT_W'(CAPACITY);
  assign empty    = count_q == '0;
  assign found    = |hit_w;

  // Row control: only an accepted change reaches the cells.
  always_comb begin
    ctrl.key = key_q;
    ctrl.op  = skl_pkg::OP_HOLD;
    if (state_q == ST_EXEC) begin
      if (cmd_q == skl_pkg::CMD_INSERT && !full) begin
        ctrl.op = skl_pkg::OP_INSERT;
      end else if (cmd_q == skl_pkg::CMD_DELETE && !empty && found) begin
        ctrl.op = skl_pkg::OP_DELETE;
      end
    end
  end

  // Row of entry cells, each wired to its two neighbors.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                   left_lt;
    logic [KB-1:0]          left_key, right_key;
    logic [HANDLE_BITS-1:0] left_handle, right_handle;

    if (i == 0) begin : g_first
      assign left_lt     = 1'b1;
      assign left_key    = '0;
      assign left_handle = '0;
    end else begin : g_mid
      assign left_lt     = lt_w[i-1];
      assign left_key    = key_w[i-1];
      assign left_handle = handle_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_key    = key_w[i];
      assign right_handle = handle_w[i];
    end else begin : g_inner
      assign right_key    = key_w[i+1];
      assign right_handle = handle_w[i+1];
    end

    skl_cell #(
      .INDEX       (i),
      .CNT_W       (CNT_W),
      .HANDLE_BITS (HANDLE_BITS)
    ) u_cell (
      .clk_i          (clk_i),
      .ctrl_i         (ctrl),
      .handle_i       (handle_q),
      .count_i        (count_q),
      .left_lt_i      (left_lt),
      .left_key_i     (left_key),
      .left_handle_i  (left_handle),
      .right_key_i    (right_key),
      .right_handle_i (right_handle),
      .key_o          (key_w[i]),
      .handle_o       (handle_w[i]),
      .lt_o           (lt_w[i]),
      .bound_o        (bound_w[i]),
      .hit_o          (hit_w[i])
    );
  end

  skl_pos_enc #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
  ) u_pos_enc (
    .bound_i (bound_w),
    .pos_o   (pos)
  );

  // Status and new entry count of the update cycle.
  always_comb begin
    status_d = skl_pkg::STATUS_DONE;
    count_d  = count_q;
    if (cmd_q == skl_pkg::CMD_INSERT) begin
      if (full) begin
        status_d = skl_pkg::STATUS_FULL;
      end else begin
        count_d = count_q + 1'b1;
      end
    end else begin
      if (empty) begin
        status_d = skl_pkg::STATUS_EMPTY;
      end else if (found) begin
        count_d = count_q - 1'b1;
      end else begin
        status_d = skl_pkg::STATUS_NOT_FOUND;
      end
    end
  end

  // Compare charge: smaller entries plus one, capped at the entries held.
  assign pos_inc    = pos_q + 1'b1;
  assign charge_amt = (pos_q >= old_count_q) ? old_count_q : pos_inc;
  assign sum        = {1'b0, total_q} + (skl_pkg::TotalBits + 1)'(charge_amt);

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_req) state_d = ST_EXEC;
      ST_EXEC:   state_d = ST_CHARGE;
      ST_CHARGE: if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_EXEC) begin
        count_q <= count_d;
      end
      if (state_q == ST_CHARGE && out_free) begin
        out_valid_q <= 1'b1;
        if (charge_q) begin
          total_q <= sum[skl_pkg::TotalBits] ? '1 : sum[skl_pkg::TotalBits-1:0];
        end
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk_i) begin
    if (in_req) begin
      cmd_q    <= s_axis_tuser;
      key_q    <= s_axis_tdata[KB-1:0];
      handle_q <= s_axis_tdata[KB +: HANDLE_BITS];
    end
    if (state_q == ST_EXEC) begin
      pos_q       <= pos;
      old_count_q <= count_q;
      status_q    <= status_d;
      charge_q    <= (status_d == skl_pkg::STATUS_DONE) ||
                     (status_d == skl_pkg::STATUS_NOT_FOUND);
    end
    if (state_q == ST_CHARGE && out_free) begin
      out_status_q <= status_q;
      out_total_q  <= (charge_q && sum[skl_pkg::TotalBits]) ? '1 :
                      (charge_q ? sum[skl_pkg::TotalBits-1:0] : total_q);
      out_occ_q    <= skl_pkg::OccBits'(count_q);
    end
  end

  assign s_axis_tready = state_q == ST_IDLE;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = OUT_W'({out_occ_q, out_total_q});

  // The entry count never passes the table size.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // At most one cell marks the search position.
  a_bound_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EXEC |-> $onehot0(bound_w))
    else $error("several search positions flagged");

  // An empty-table result always reports zero entries.
  a_empty_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == skl_pkg::STATUS_EMPTY) |-> out_occ_q == '0)
    else $error("empty status with entries held");

  // The update cycle always hands over to the charge cycle.
  a_exec_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EXEC |=> state_q == ST_CHARGE)
    else $error("update cycle not followed by charge cycle");

endmodule
